/* rtl/core/masked_rotation_cursor_macros.svh */
// ----------------------------------------------------------------------------
// masked_rotation_cursor_macros.svh
// Assertion shorthands for the rotation cursor checks. They expect signals
// named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MASKED_ROTATION_CURSOR_MACROS_SVH
`define MASKED_ROTATION_CURSOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MRC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MRC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the masked rotation cursor.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

	localparam int MAX_ORDER = 256;
	localparam int MAX_IDS   = 256;
	localparam int POS_W     = $clog2(MAX_ORDER);
	localparam int LEN_W     = POS_W + 1;
	localparam int ID_W      = $clog2(MAX_IDS);
	localparam int OFF_W     = 8;
	localparam int OP_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_WR_SLOT = 2'd0,
		OP_WR_EXCL = 2'd1,
		OP_QUERY   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MK,
		S_EV,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        slot;
		logic [ID_W-1:0]         entry_id;
		logic                    exclude_bit;
		logic signed [OFF_W-1:0] offset;
	} item_t;

	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] chosen_id;
	} result_t;

	typedef struct packed {
		logic             tab_we;
		logic             msk_we;
		logic [POS_W-1:0] wslot;
		logic [ID_W-1:0]  wid;
		logic             wbit;
		logic             tab_re;
		logic [POS_W-1:0] raddr;
		logic             msk_re;
	} store_req_t;

	typedef struct packed {
		logic [ID_W-1:0] tab_rdata;
		logic            eligible;
	} store_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/mrc_step.sv */
// ----------------------------------------------------------------------------
// mrc_step
// Shared position stepper: one slot forward or backward with wrap-around
// over the slots in use.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_step (
	input  wire logic [mrc_pkg::POS_W-1:0] pos,
	input  wire logic [mrc_pkg::POS_W-1:0] last,
	input  wire logic                      backward,
	output logic      [mrc_pkg::POS_W-1:0] next
);
	import mrc_pkg::*;

	// wrap at either end of the used range
	always_comb begin
		if (backward) begin
			next = (pos == '0) ? last : pos - 1'b1;
		end else begin
			next = (pos == last) ? '0 : pos + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/mrc_store.sv */
// ----------------------------------------------------------------------------
// mrc_store
// Order table memory and exclusion mask memory. The mask read is addressed
// by the registered table read data, so one slot is looked up in two reads.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_store (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mrc_pkg::store_req_t req,
	output mrc_pkg::store_rsp_t      rsp
);
	import mrc_pkg::*;

	logic [ID_W-1:0]    tab_mem [MAX_ORDER];
	logic               msk_mem [MAX_IDS];
	logic [MAX_IDS-1:0] vld_q;
	logic [ID_W-1:0]    tab_rd_q;
	logic               msk_rd_q;
	logic               vld_rd_q;

	// table and mask ports, read data registered
	always_ff @(posedge clk) begin
		if (req.tab_we) begin
			tab_mem[req.wslot] <= req.wid;
		end
		if (req.tab_re) begin
			tab_rd_q <= tab_mem[req.raddr];
		end
		if (req.msk_we) begin
			msk_mem[req.wid] <= req.wbit;
		end
		if (req.msk_re) begin
			msk_rd_q <= msk_mem[tab_rd_q];
			vld_rd_q <= vld_q[tab_rd_q];
		end
	end

	// mark mask entries written since reset; others read as not excluded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.msk_we) begin
			vld_q[req.wid] <= 1'b1;
		end
	end

	assign rsp.tab_rdata = tab_rd_q;
	assign rsp.eligible  = !(msk_rd_q && vld_rd_q);

endmodule

`default_nettype wire

/* rtl/core/mrc_ctrl.sv */
// ----------------------------------------------------------------------------
// mrc_ctrl
// Query sequencer. A scan pass over all used slots finds the anchor and the
// first and last eligible entries; when both were seen, a walk pass then
// steps slot by slot with the shared stepper past enough eligible entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire mrc_pkg::item_t            item,
	input  wire logic [mrc_pkg::LEN_W-1:0] len,
	output logic                           busy,
	output logic                           done,
	output mrc_pkg::result_t               result,
	output mrc_pkg::store_req_t            req,
	input  wire mrc_pkg::store_rsp_t       rsp
);
	import mrc_pkg::*;

	state_t           state_q, state_d;
	logic             done_q;
	result_t          res_q;

	logic [POS_W-1:0] pos_q, last_q, anc_pos_q;
	logic [ID_W-1:0]  anchor_id_q, first_id_q, last_id_q;
	logic [OFF_W-1:0] mag_q, rem_q;
	logic             neg_q, walk_q, back_q;
	logic             any_q, first_seen_q, anc_found_q;

	logic [LEN_W-1:0] n_act;
	logic [OFF_W-1:0] off_u, mag_d;
	logic             mag_nz;
	logic             elig;
	logic [ID_W-1:0]  d;
	logic             any_n, first_seen_n, anc_found_n, hit, scan_end;
	logic [ID_W-1:0]  first_id_n, last_id_n;
	logic [POS_W-1:0] anc_pos_n;
	logic [POS_W-1:0] step_in, step_out;
	logic             step_back;
	logic             fin, fin_found;
	logic [ID_W-1:0]  fin_id;
	logic             query_go;

	// clamp the length and take the offset apart
	assign n_act    = (len > LEN_W'(MAX_ORDER)) ? LEN_W'(MAX_ORDER) : len;
	assign off_u    = item.offset;
	assign mag_d    = off_u[OFF_W-1] ? (~off_u + 1'b1) : off_u;
	assign mag_nz   = (mag_q != '0);
	assign query_go = (state_q == S_IDLE) && start && (item.op == OP_QUERY);

	// per-slot evaluation of the scan pass
	assign elig         = rsp.eligible;
	assign d            = rsp.tab_rdata;
	assign any_n        = any_q || elig;
	assign first_seen_n = first_seen_q || elig;
	assign first_id_n   = (!first_seen_q && elig) ? d : first_id_q;
	assign last_id_n    = elig ? d : last_id_q;
	assign hit          = !anc_found_q && (d == anchor_id_q);
	assign anc_found_n  = anc_found_q || hit;
	assign anc_pos_n    = hit ? pos_q : anc_pos_q;
	assign scan_end     = (pos_q == last_q);

	// shared stepper: scan forward, then the walk start, then the walk
	assign step_in   = (!walk_q && scan_end) ? anc_pos_n : pos_q;
	assign step_back = walk_q ? back_q : (scan_end && neg_q && mag_nz);

	mrc_step u_step (
		.pos      (step_in),
		.last     (last_q),
		.backward (step_back),
		.next     (step_out)
	);

	// next state, store requests and finish decision
	always_comb begin
		state_d    = state_q;
		req        = '0;
		req.wslot  = item.slot;
		req.wid    = item.entry_id;
		req.wbit   = item.exclude_bit;
		req.raddr  = pos_q;
		fin        = 1'b0;
		fin_found  = 1'b0;
		fin_id     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (item.op)
						OP_WR_SLOT: req.tab_we = 1'b1;
						OP_WR_EXCL: req.msk_we = 1'b1;
						OP_QUERY:   state_d = (n_act == '0) ? S_EMPTY : S_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_RD: begin
				req.tab_re = 1'b1;
				state_d    = S_MK;
			end
			S_MK: begin
				req.msk_re = 1'b1;
				state_d    = S_EV;
			end
			S_EV: begin
				state_d = S_RD;
				if (!walk_q) begin
					if (scan_end && !any_n) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else if (scan_end && !anc_found_n) begin
						fin       = 1'b1;
						fin_found = 1'b1;
						fin_id    = neg_q ? last_id_n : first_id_n;
						state_d   = S_IDLE;
					end
				end else if (elig && rem_q == OFF_W'(1)) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_id    = d;
					state_d   = S_IDLE;
				end
			end
			S_EMPTY: begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// hold the result beat
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q.found     <= fin_found;
			res_q.chosen_id <= fin_id;
		end
	end

	// sequencer working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			last_q       <= '0;
			anc_pos_q    <= '0;
			anchor_id_q  <= '0;
			first_id_q   <= '0;
			last_id_q    <= '0;
			mag_q        <= '0;
			rem_q        <= '0;
			neg_q        <= 1'b0;
			walk_q       <= 1'b0;
			back_q       <= 1'b0;
			any_q        <= 1'b0;
			first_seen_q <= 1'b0;
			anc_found_q  <= 1'b0;
		end else if (query_go) begin
			pos_q        <= '0;
			last_q       <= POS_W'(n_act - 1'b1);
			anchor_id_q  <= item.entry_id;
			neg_q        <= off_u[OFF_W-1];
			mag_q        <= mag_d;
			walk_q       <= 1'b0;
			any_q        <= 1'b0;
			first_seen_q <= 1'b0;
			anc_found_q  <= 1'b0;
		end else if (state_q == S_EV && !walk_q) begin
			any_q        <= any_n;
			first_seen_q <= first_seen_n;
			first_id_q   <= first_id_n;
			last_id_q    <= last_id_n;
			anc_found_q  <= anc_found_n;
			anc_pos_q    <= anc_pos_n;
			if (scan_end) begin
				// set up the walk from the anchor
				walk_q <= 1'b1;
				back_q <= neg_q && mag_nz;
				pos_q  <= mag_nz ? step_out : anc_pos_n;
				rem_q  <= mag_nz ? mag_q : OFF_W'(1);
			end else begin
				pos_q <= step_out;
			end
		end else if (state_q == S_EV) begin
			// advance the walk, count eligible slots passed
			if (elig) begin
				rem_q <= rem_q - 1'b1;
			end
			pos_q <= step_out;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* rtl/core/masked_rotation_cursor.sv */
// ----------------------------------------------------------------------------
// masked_rotation_cursor
// Rotation order cursor with a per-id exclusion mask.
// ----------------------------------------------------------------------------
// Usage:
//   An item beat is taken when start is high and busy is low. Op 0 writes
//   one order table slot and op 1 one exclusion bit; both complete in the
//   cycle they are taken, give no result and leave busy low. Op 3 is
//   dropped. Op 2 is a query: busy rises and stays high until its result.
//   A query result is shown on result for one cycle with done high; the
//   receiver cannot hold it off. order_length is written through cfg_we/cfg_wdata;
//   the user does so only while idle, which the block itself does not enforce.
// Timing:
//   Each slot is looked at by a table read, a mask read and a decision.
//   A query runs one scan pass over all n used slots, then a walk of w
//   slots from the anchor; done is registered from the decision on the
//   last slot (from S_EMPTY when n is 0), and busy falls with it, so the
//   next beat can be taken while done is high. w is 0 when the anchor is
//   absent or nothing is eligible; otherwise w is at least 1 and grows
//   with |offset| and the share of excluded slots.
// Reset:
//   order_length and the exclusion mask clear at once; table slots are
//   undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_rotation_cursor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire mrc_pkg::item_t            item,
	output logic                           done,
	output mrc_pkg::result_t               result,
	input  wire logic                      cfg_we,
	input  wire logic [mrc_pkg::LEN_W-1:0] cfg_wdata
);
	import mrc_pkg::*;

	logic [LEN_W-1:0] len_q;
	store_req_t       req;
	store_rsp_t       rsp;

	// order length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	mrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.len    (len_q),
		.busy   (busy),
		.done   (done),
		.result (result),
		.req    (req),
		.rsp    (rsp)
	);

	mrc_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* rtl/core/mrc_checker.sv */
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks of the query handshake, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_rotation_cursor_macros.svh"

module mrc_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             busy,
	input wire logic             done,
	input wire mrc_pkg::result_t result
);
	import mrc_pkg::*;

	// a result beat only ends a query that held busy
	`MRC_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result beat without a query")
	// busy drops only with a result beat
	`MRC_ASSERT_IMP(a_busy_ends_done, $fell(busy), done, "query ended without a result")
	// one beat per query
	`MRC_ASSERT_NXT(a_done_single, done, !done, "result beat repeated")
	// nothing chosen reads as id zero
	`MRC_ASSERT_IMP(a_miss_zero, done && !result.found, result.chosen_id == '0, "miss id not 0")

endmodule

bind masked_rotation_cursor mrc_checker u_mrc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
